// ===== rtl/dqpb_pkg.sv =====
// Shared constants, types and command/status bundles for the DNS query builder.
`default_nettype none

package dqpb_pkg;

   localparam int LABEL_MAX   = 32;
   localparam int HDR_BYTES   = 12;
   localparam int TRL_BYTES   = 5;
   localparam int LEN_W       = $clog2(LABEL_MAX + 1);
   localparam int ADDR_W      = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
   localparam int CNT_MAX     = (LABEL_MAX > HDR_BYTES) ? LABEL_MAX : HDR_BYTES;
   localparam int CNT_W       = $clog2(CNT_MAX + 1);
   localparam int CSR_ADDR_W  = 5;

   localparam logic [7:0] DOT_CHAR = 8'd46;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_QUERY_ID       = 3'd0;
   localparam logic [2:0] REG_OPCODE         = 3'd1;
   localparam logic [2:0] REG_RECURSION      = 3'd2;
   localparam logic [2:0] REG_QUESTION_COUNT = 3'd3;
   localparam logic [2:0] REG_QUERY_TYPE     = 3'd4;
   localparam logic [2:0] REG_QUERY_CLASS    = 3'd5;

   typedef enum logic [1:0] {
      SEL_HDR  = 2'd0,
      SEL_LEN  = 2'd1,
      SEL_DATA = 2'd2,
      SEL_TRL  = 2'd3
   } byte_sel_type;

   typedef struct packed {
      logic                accept;      // take the waiting request
      logic                load;        // load output register
      byte_sel_type        sel;
      logic [CNT_W-1:0]    idx;
      logic                last;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
      logic                clear_label;
      logic                clear_hdr;
   } cmd_type;

   typedef struct packed {
      logic                can_load;
      logic                header_sent;
      logic                in_flush;    // incoming char ends a label
      logic                item_flush;
      logic                item_last;
      logic [LEN_W-1:0]    label_len;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/dqpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dqpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dqpb_ctrl.sv =====
// Sequencer: walks header, label flush and trailer one byte per step.
`default_nettype none

module dqpb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire dqpb_pkg::status_type  status,
   output dqpb_pkg::cmd_type          cmd
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HDR  = 5'b00010,
      S_LEN  = 5'b00100,
      S_DATA = 5'b01000,
      S_TRL  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [dqpb_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [dqpb_pkg::CNT_W-1:0]    cnt_inc;
   logic                          data_end;

   assign req_tready = (state_ff == S_IDLE);
   assign cnt_inc    = dqpb_pkg::CNT_W'(cnt_ff + 1'b1);
   assign data_end   = (cnt_inc == dqpb_pkg::CNT_W'(status.label_len));

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      cmd             = '0;
      cmd.sel         = dqpb_pkg::SEL_HDR;
      cmd.idx         = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               if (!status.header_sent) begin
                  state_in = S_HDR;
               end else if (status.in_flush) begin
                  state_in = S_LEN;
               end
            end
         end
         S_HDR: begin
            if (status.can_load) begin
               cmd.load = 1'b1;
               cmd.sel  = dqpb_pkg::SEL_HDR;
               cnt_in   = cnt_inc;
               if (cnt_ff == dqpb_pkg::CNT_W'(dqpb_pkg::HDR_BYTES - 1)) begin
                  cnt_in   = '0;
                  state_in = status.item_flush ? S_LEN : S_IDLE;
               end
            end
         end
         S_LEN: begin
            if (status.can_load) begin
               cmd.load    = 1'b1;
               cmd.sel     = dqpb_pkg::SEL_LEN;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = '0;
               cnt_in      = '0;
               if (status.label_len == '0) begin
                  cmd.clear_label = 1'b1;
                  state_in        = status.item_last ? S_TRL : S_IDLE;
               end else begin
                  state_in = S_DATA;
               end
            end
         end
         S_DATA: begin
            if (status.can_load) begin
               cmd.load    = 1'b1;
               cmd.sel     = dqpb_pkg::SEL_DATA;
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = cnt_inc[dqpb_pkg::ADDR_W-1:0];
               cnt_in      = cnt_inc;
               if (data_end) begin
                  cmd.clear_label = 1'b1;
                  cnt_in          = '0;
                  state_in        = status.item_last ? S_TRL : S_IDLE;
               end
            end
         end
         S_TRL: begin
            if (status.can_load) begin
               cmd.load = 1'b1;
               cmd.sel  = dqpb_pkg::SEL_TRL;
               cnt_in   = cnt_inc;
               if (cnt_ff == dqpb_pkg::CNT_W'(dqpb_pkg::TRL_BYTES - 1)) begin
                  cmd.last      = 1'b1;
                  cmd.clear_hdr = 1'b1;
                  cnt_in        = '0;
                  state_in      = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // a label byte is only ever sent from inside the buffered label
   a_data_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DATA && cmd.load) |->
         (cnt_ff < dqpb_pkg::CNT_W'(status.label_len)))
      else $error("label read past buffered length");

   // header is never sent twice for one name
   a_hdr_once: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.header_sent) |=> (state_ff != S_HDR))
      else $error("header walk with header already sent");

endmodule

`default_nettype wire

// ===== rtl/dqpb_dp.sv =====
// Datapath: CSRs, label buffer and length, byte select and output register.
`default_nettype none

module dqpb_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request side
   input  wire logic [7:0]                          req_tdata,
   input  wire logic                                req_tlast,
   // result side
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [7:0]                               rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tuser,
   // CSR port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [dqpb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   // controller
   input  wire dqpb_pkg::cmd_type                   cmd,
   output dqpb_pkg::status_type                     status
);

   logic [15:0]                  query_id_ff, query_id_in;
   logic [3:0]                   opcode_ff, opcode_in;
   logic                         rd_ff, rd_in;
   logic [15:0]                  qcount_ff, qcount_in;
   logic [15:0]                  qtype_ff, qtype_in;
   logic [15:0]                  qclass_ff, qclass_in;

   logic                         hdr_sent_ff, hdr_sent_in;
   logic [dqpb_pkg::LEN_W-1:0]   len_ff, len_in;
   logic                         ovf_ff, ovf_in;
   logic                         item_flush_ff, item_flush_in;
   logic                         item_last_ff, item_last_in;

   logic                         out_valid_ff, out_valid_in;
   logic [7:0]                   out_byte_ff, out_byte_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_trunc_ff, out_trunc_in;

   logic                         csr_wr;
   logic [2:0]                   csr_idx;
   logic                         is_dot;
   logic                         label_full;
   logic                         ram_we;
   logic [7:0]                   ram_rdata;
   logic [7:0]                   sel_byte;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];
   assign is_dot     = (req_tdata == dqpb_pkg::DOT_CHAR);
   assign label_full = (len_ff == dqpb_pkg::LEN_W'(dqpb_pkg::LABEL_MAX));
   assign ram_we     = cmd.accept && !is_dot && !label_full;

   // CSR write and read
   always_comb begin
      query_id_in = query_id_ff;
      opcode_in   = opcode_ff;
      rd_in       = rd_ff;
      qcount_in   = qcount_ff;
      qtype_in    = qtype_ff;
      qclass_in   = qclass_ff;
      csr_prdata  = '0;
      if (csr_wr) begin
         unique case (csr_idx)
            dqpb_pkg::REG_QUERY_ID:       query_id_in = csr_pwdata[15:0];
            dqpb_pkg::REG_OPCODE:         opcode_in   = csr_pwdata[3:0];
            dqpb_pkg::REG_RECURSION:      rd_in       = csr_pwdata[0];
            dqpb_pkg::REG_QUESTION_COUNT: qcount_in   = csr_pwdata[15:0];
            dqpb_pkg::REG_QUERY_TYPE:     qtype_in    = csr_pwdata[15:0];
            dqpb_pkg::REG_QUERY_CLASS:    qclass_in   = csr_pwdata[15:0];
            default: ;
         endcase
      end
      unique case (csr_idx)
         dqpb_pkg::REG_QUERY_ID:       csr_prdata = {16'd0, query_id_ff};
         dqpb_pkg::REG_OPCODE:         csr_prdata = {28'd0, opcode_ff};
         dqpb_pkg::REG_RECURSION:      csr_prdata = {31'd0, rd_ff};
         dqpb_pkg::REG_QUESTION_COUNT: csr_prdata = {16'd0, qcount_ff};
         dqpb_pkg::REG_QUERY_TYPE:     csr_prdata = {16'd0, qtype_ff};
         dqpb_pkg::REG_QUERY_CLASS:    csr_prdata = {16'd0, qclass_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // label and message state
   always_comb begin
      hdr_sent_in   = hdr_sent_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      item_flush_in = item_flush_ff;
      item_last_in  = item_last_ff;
      if (cmd.accept) begin
         hdr_sent_in   = 1'b1;
         item_flush_in = is_dot || req_tlast;
         item_last_in  = req_tlast;
         if (!is_dot) begin
            if (label_full) begin
               ovf_in = 1'b1;
            end else begin
               len_in = dqpb_pkg::LEN_W'(len_ff + 1'b1);
            end
         end
      end
      if (cmd.clear_label) begin
         len_in = '0;
         ovf_in = 1'b0;
      end
      if (cmd.clear_hdr) begin
         hdr_sent_in = 1'b0;
      end
   end

   // byte select
   always_comb begin
      sel_byte = 8'd0;
      unique case (cmd.sel)
         dqpb_pkg::SEL_HDR: begin
            unique case (cmd.idx)
               dqpb_pkg::CNT_W'(0): sel_byte = query_id_ff[15:8];
               dqpb_pkg::CNT_W'(1): sel_byte = query_id_ff[7:0];
               dqpb_pkg::CNT_W'(2): sel_byte = {1'b0, opcode_ff, 2'b00, rd_ff};
               dqpb_pkg::CNT_W'(4): sel_byte = qcount_ff[15:8];
               dqpb_pkg::CNT_W'(5): sel_byte = qcount_ff[7:0];
               default:             sel_byte = 8'd0;
            endcase
         end
         dqpb_pkg::SEL_LEN:  sel_byte = 8'(len_ff);
         dqpb_pkg::SEL_DATA: sel_byte = ram_rdata;
         dqpb_pkg::SEL_TRL: begin
            unique case (cmd.idx)
               dqpb_pkg::CNT_W'(1): sel_byte = qtype_ff[15:8];
               dqpb_pkg::CNT_W'(2): sel_byte = qtype_ff[7:0];
               dqpb_pkg::CNT_W'(3): sel_byte = qclass_ff[15:8];
               dqpb_pkg::CNT_W'(4): sel_byte = qclass_ff[7:0];
               default:             sel_byte = 8'd0;
            endcase
         end
         default: sel_byte = 8'd0;
      endcase
   end

   // output register
   always_comb begin
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_trunc_in = out_trunc_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (cmd.load) begin
         out_valid_in = 1'b1;
         out_byte_in  = sel_byte;
         out_last_in  = cmd.last;
         out_trunc_in = (cmd.sel == dqpb_pkg::SEL_LEN) && ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_id_ff   <= 16'd0;
         opcode_ff     <= 4'd0;
         rd_ff         <= 1'b1;
         qcount_ff     <= 16'd1;
         qtype_ff      <= 16'd1;
         qclass_ff     <= 16'd1;
         hdr_sent_ff   <= 1'b0;
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         item_flush_ff <= 1'b0;
         item_last_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         query_id_ff   <= query_id_in;
         opcode_ff     <= opcode_in;
         rd_ff         <= rd_in;
         qcount_ff     <= qcount_in;
         qtype_ff      <= qtype_in;
         qclass_ff     <= qclass_in;
         hdr_sent_ff   <= hdr_sent_in;
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
         item_flush_ff <= item_flush_in;
         item_last_ff  <= item_last_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   dqpb_ram #(
      .WIDTH (8),
      .DEPTH (dqpb_pkg::LABEL_MAX)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (len_ff[dqpb_pkg::ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (ram_rdata)
   );

   assign status.can_load    = !out_valid_ff || rsp_tready;
   assign status.header_sent = hdr_sent_ff;
   assign status.in_flush    = is_dot || req_tlast;
   assign status.item_flush  = item_flush_ff;
   assign status.item_last   = item_last_ff;
   assign status.label_len   = len_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_trunc_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= dqpb_pkg::LEN_W'(dqpb_pkg::LABEL_MAX))
      else $error("label length beyond limit");

   a_trunc_only_len: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.sel != dqpb_pkg::SEL_LEN) |=> !out_trunc_ff)
      else $error("truncation flag on a non-length byte");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten while held");

endmodule

`default_nettype wire

// ===== rtl/dns_query_packet_builder.sv =====
// Top level of the DNS query message builder: controller plus datapath.
//
//  channel   dir   handshake               payload
//  req_*     in    req_tvalid/req_tready   tdata[7:0]=name_char, tlast=is_last
//  rsp_*     out   rsp_tvalid/rsp_tready   tdata[7:0]=out_byte, tlast=last_byte,
//                                          tuser=label_truncated
//  csr_*     in    psel/penable/pready     6 regs at 4*i, pready tied high
//
// The first character of a name adds the 12 header bytes; a dot or the last
// character adds the length byte and the label bytes for the flush, and the last
// character a further 5 trailer bytes. Bytes leave at one per cycle while
// rsp_tready is high; a stall on the result side holds the sequencer.
// Synchronous active-high reset, no clearing pass: only label bytes below the
// stored length are sent.
`default_nettype none

module dns_query_packet_builder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,   // [7:0] name_char
   input  wire logic                             req_tlast,   // is_last
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [7:0]                            rsp_tdata,   // [7:0] out_byte
   output logic                                  rsp_tlast,   // last_byte
   output logic                                  rsp_tuser,   // [0] label_truncated
   // CSR port
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [dqpb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                      csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   dqpb_pkg::cmd_type     cmd;
   dqpb_pkg::status_type  status;

   // no wait states on the CSR port
   assign csr_pready = 1'b1;

   // sequencer: header, label flush, trailer
   dqpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // registers, label buffer and output stage
   dqpb_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire
